@@ rtl/mtq_pkg.sv @@
// Package with the word types, codes and depth defaults of the tag match queue.
package mtq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TagBits    = 15;
  localparam int unsigned HandleBits = 8;

  localparam logic [1:0] CMD_NB_SEND = 2'd0;
  localparam logic [1:0] CMD_NB_RECV = 2'd1;
  localparam logic [1:0] CMD_B_SEND  = 2'd2;
  localparam logic [1:0] CMD_B_RECV  = 2'd3;

  localparam logic [1:0] ST_MATCHED = 2'd0;
  localparam logic [1:0] ST_QUEUED  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  handle;
    logic [14:0] msg_tag;
    logic        tag_wildcard;
    logic [7:0]  communicator;
    logic [19:0] byte_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  matched_handle;
    logic [19:0] matched_size;
    logic        size_error;
  } out_word_t;

  typedef struct packed {
    logic     is_send;
    logic     blocking;
    in_word_t word;
  } cls_req_t;

endpackage

@@ rtl/mtq_fifo.sv @@
// Two-entry first-in first-out buffer used between the stages of the block.
module mtq_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  logic [Width-1:0] mem_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end
endmodule

@@ rtl/mtq_front.sv @@
// Front end that accepts request words, classifies them and buffers them.
module mtq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mtq_pkg::in_word_t in_word_i,
  output logic              full_o,
  input  logic              req_pop_i,
  output mtq_pkg::cls_req_t req_o,
  output logic              req_valid_o
);
  import mtq_pkg::*;

  cls_req_t cls;
  logic     req_empty;

  always_comb begin
    cls.word     = in_word_i;
    cls.is_send  = (in_word_i.command == CMD_NB_SEND) || (in_word_i.command == CMD_B_SEND);
    cls.blocking = (in_word_i.command == CMD_B_SEND) || (in_word_i.command == CMD_B_RECV);
  end

  mtq_fifo #(.Width($bits(cls_req_t))) u_req_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cls),
    .full_o (full_o),
    .pop_i  (req_pop_i),
    .data_o (req_o),
    .empty_o(req_empty)
  );

  assign req_valid_o = !req_empty;
endmodule

@@ rtl/mtq_engine.sv @@
// Matching engine holding the send and receive shift queues.
module mtq_engine #(
  parameter int unsigned QueueDepth = mtq_pkg::QueueDepth,
  parameter int unsigned TagBits    = mtq_pkg::TagBits,
  parameter int unsigned HandleBits = mtq_pkg::HandleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtq_pkg::cls_req_t  req_i,
  input  logic               req_valid_i,
  output logic               req_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output mtq_pkg::out_word_t res_o
);
  import mtq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_RES  = 3'b100
  } state_e;

  state_e state_q, state_d;
  cls_req_t req_q;
  logic [QueueDepth-1:0] hit_q, hit_d;
  logic [CntW-1:0] cnt_q [2];

  logic [HandleBits-1:0] hdl_q  [2][QueueDepth];
  logic [TagBits-1:0]    tag_q  [2][QueueDepth];
  logic                  wild_q [2][QueueDepth];
  logic [7:0]            comm_q [2][QueueDepth];
  logic [19:0]           size_q [2][QueueDepth];

  logic                  oth, own;
  logic [TagBits-1:0]    req_tag;
  logic [HandleBits-1:0] req_hdl;
  logic                  found, own_full, append;
  logic [IdxW-1:0]       idx;
  logic [19:0]           p_size;

  assign oth      = req_q.is_send;
  assign own      = ~req_q.is_send;
  assign req_tag  = TagBits'(req_q.word.msg_tag);
  assign req_hdl  = HandleBits'(req_q.word.handle);
  assign own_full = (cnt_q[own] == CntW'(QueueDepth));
  assign append   = !found && !req_q.blocking && !own_full;

  assign req_pop_o  = (state_q == S_IDLE) && req_valid_i && !res_full_i;
  assign res_push_o = (state_q == S_RES);

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      hit_d[i] = (CntW'(i) < cnt_q[oth])
              && (comm_q[oth][i] == req_q.word.communicator)
              && (wild_q[oth][i] || req_q.word.tag_wildcard || (tag_q[oth][i] == req_tag));
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        found = 1'b1;
        idx   = IdxW'(i);
      end
    end
  end

  assign p_size = size_q[oth][idx];

  always_comb begin
    res_o = '0;
    if (found) begin
      res_o.status         = ST_MATCHED;
      res_o.matched_handle = 8'(hdl_q[oth][idx]);
      res_o.matched_size   = p_size;
      res_o.size_error     = req_q.is_send ? (req_q.word.byte_size > p_size)
                                           : (p_size > req_q.word.byte_size);
    end else if (req_q.blocking) begin
      res_o.status = ST_NOMATCH;
    end else if (own_full) begin
      res_o.status = ST_FULL;
    end else begin
      res_o.status = ST_QUEUED;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_pop_o) state_d = S_CMP;
      S_CMP:  state_d = S_RES;
      S_RES:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_RES) begin
        if (found) begin
          cnt_q[oth] <= cnt_q[oth] - CntW'(1);
        end else if (append) begin
          cnt_q[own] <= cnt_q[own] + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      req_q <= req_i;
    end
    if (state_q == S_CMP) begin
      hit_q <= hit_d;
    end
    if (state_q == S_RES) begin
      if (found) begin
        for (int i = 0; i < QueueDepth - 1; i++) begin
          if (i >= int'(idx)) begin
            hdl_q[oth][i]  <= hdl_q[oth][i+1];
            tag_q[oth][i]  <= tag_q[oth][i+1];
            wild_q[oth][i] <= wild_q[oth][i+1];
            comm_q[oth][i] <= comm_q[oth][i+1];
            size_q[oth][i] <= size_q[oth][i+1];
          end
        end
      end else if (append) begin
        hdl_q[own][cnt_q[own][IdxW-1:0]]  <= req_hdl;
        tag_q[own][cnt_q[own][IdxW-1:0]]  <= req_tag;
        wild_q[own][cnt_q[own][IdxW-1:0]] <= req_q.word.tag_wildcard;
        comm_q[own][cnt_q[own][IdxW-1:0]] <= req_q.word.communicator;
        size_q[own][cnt_q[own][IdxW-1:0]] <= req_q.word.byte_size;
      end
    end
  end
endmodule

@@ rtl/mpi_tag_match_queue.sv @@
// Top level of the message tag matching engine with send and receive queues.
// Requests enter as words on in_word_i: a word is taken at a clock edge with
// push high and full low. Results leave in order on out_word_o: the oldest
// result is shown while empty is low and is taken at an edge with pop high.
// Every request yields exactly one result word.
// A request waits in a two-entry input buffer until the matching engine loads
// it, then the engine runs a parallel compare against the opposite queue and
// then picks the oldest hit and removes or appends an entry, pushing the result
// into the output buffer. The engine takes no new request until it has pushed
// the result of the last one.
// Results wait in a two-entry output buffer. When the receiver stalls, the
// engine stops once that buffer is full and the input buffer then fills and
// raises full.
// Reset empties both queues and both buffers; the block is ready at once.
module mpi_tag_match_queue #(
  parameter int unsigned QueueDepth = mtq_pkg::QueueDepth,
  parameter int unsigned TagBits    = mtq_pkg::TagBits,
  parameter int unsigned HandleBits = mtq_pkg::HandleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  mtq_pkg::in_word_t  in_word_i,
  output logic               full,
  input  logic               pop,
  output mtq_pkg::out_word_t out_word_o,
  output logic               empty
);
  import mtq_pkg::*;

  cls_req_t  req;
  logic      req_valid, req_pop, res_full, res_push;
  out_word_t res;

  mtq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .req_pop_i  (req_pop),
    .req_o      (req),
    .req_valid_o(req_valid)
  );

  mtq_engine #(
    .QueueDepth(QueueDepth),
    .TagBits   (TagBits),
    .HandleBits(HandleBits)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .req_valid_i(req_valid),
    .req_pop_o  (req_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  mtq_fifo #(.Width($bits(out_word_t))) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_word_o),
    .empty_o(empty)
  );
endmodule

@@ rtl/mtq_checker.sv @@
// Port checker for the tag match queue and its bind to the top level.
module mtq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               pop,
  input mtq_pkg::out_word_t out_word_o,
  input logic               empty
);
  import mtq_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> empty) else $error("result present right after reset");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_word_o))
    else $error("waiting result changed");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.status != ST_MATCHED |->
      out_word_o.matched_handle == 8'd0 && out_word_o.matched_size == 20'd0
      && !out_word_o.size_error)
    else $error("unmatched result carries partner fields");

  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("input became full without a pushed word");
endmodule

bind mpi_tag_match_queue mtq_checker u_mtq_checker (.*);

@@ sim/testbench.sv @@
// Testbench for the tag match queue: random and directed requests checked against a local model.
`timescale 1ns / 1ps
module testbench;
  import mtq_pkg::*;

  typedef struct packed {
    logic [7:0]  handle;
    logic [14:0] tag;
    logic        wild;
    logic [7:0]  comm;
    logic [19:0] size;
  } entry_t;

  localparam int unsigned CycleLimit = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  in_word_t  in_word_i;
  logic      full;
  logic      pop;
  out_word_t out_word_o;
  logic      empty;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  entry_t    send_q[$];
  entry_t    recv_q[$];
  int        mismatch_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  logic      sender_pause;

  mpi_tag_match_queue u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_word_i (in_word_i),
    .full      (full),
    .pop       (pop),
    .out_word_o(out_word_o),
    .empty     (empty)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic entries_hit(entry_t a, entry_t b);
    return (a.comm == b.comm) && (a.wild || b.wild || a.tag == b.tag);
  endfunction

  function automatic out_word_t match_request(in_word_t w);
    out_word_t r;
    entry_t    req;
    entry_t    p;
    logic      is_send;
    int        idx;
    r = '0;
    is_send = (w.command == CMD_NB_SEND) || (w.command == CMD_B_SEND);
    req = '{w.handle, w.msg_tag, w.tag_wildcard, w.communicator, w.byte_size};
    idx = -1;
    if (is_send) begin
      foreach (recv_q[i]) if (idx < 0 && entries_hit(recv_q[i], req)) idx = i;
    end else begin
      foreach (send_q[i]) if (idx < 0 && entries_hit(send_q[i], req)) idx = i;
    end
    if (idx >= 0) begin
      p = is_send ? recv_q[idx] : send_q[idx];
      r.status = ST_MATCHED;
      r.matched_handle = p.handle;
      r.matched_size = p.size;
      r.size_error = is_send ? (req.size > p.size) : (p.size > req.size);
      if (is_send) recv_q.delete(idx);
      else send_q.delete(idx);
    end else if (w.command == CMD_B_SEND || w.command == CMD_B_RECV) begin
      r.status = ST_NOMATCH;
    end else if ((is_send ? send_q.size() : recv_q.size()) >= QueueDepth) begin
      r.status = ST_FULL;
    end else begin
      r.status = ST_QUEUED;
      if (is_send) send_q.push_back(req);
      else recv_q.push_back(req);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] comm, logic [14:0] tag,
                                         logic wild, logic [19:0] size);
    in_word_t w;
    w.command = cmd;
    w.handle = 8'($urandom);
    w.msg_tag = tag;
    w.tag_wildcard = wild;
    w.communicator = comm;
    w.byte_size = size;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w = make_word(2'($urandom), 8'($urandom_range(0, 3)), 15'($urandom_range(0, 3)),
                  ($urandom_range(0, 5) == 0), 20'($urandom_range(0, 40)));
    if ($urandom_range(0, 9) == 0) begin
      w.communicator = 8'($urandom);
      w.msg_tag = 15'($urandom);
      w.byte_size = 20'($urandom);
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (!(push && full)) begin
        if (pending_words.size() > 0 && !sender_pause &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_word_i <= pending_words.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) expected_words.push_back(match_request(in_word_i));
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", int'(out_word_o), 0);
      end else begin
        want = expected_words.pop_front();
        if (out_word_o.status !== want.status)
          report_mismatch("status", int'(out_word_o.status), int'(want.status));
        if (out_word_o.matched_handle !== want.matched_handle)
          report_mismatch("matched_handle", int'(out_word_o.matched_handle),
                          int'(want.matched_handle));
        if (out_word_o.matched_size !== want.matched_size)
          report_mismatch("matched_size", int'(out_word_o.matched_size),
                          int'(want.matched_size));
        if (out_word_o.size_error !== want.size_error)
          report_mismatch("size_error", int'(out_word_o.size_error), int'(want.size_error));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_words.size() == 0);
    while (push || expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pending_words.push_back(random_word());
    drain();
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    sender_pause = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_words.push_back(make_word(CMD_B_SEND, 8'd0, 15'd0, 1'b0, 20'd0));
    pending_words.push_back(make_word(CMD_B_RECV, 8'hFF, 15'h7FFF, 1'b1, 20'hFFFFF));
    pending_words.push_back(make_word(CMD_NB_SEND, 8'hFF, 15'h7FFF, 1'b0, 20'hFFFFF));
    pending_words.push_back(make_word(CMD_NB_RECV, 8'hFF, 15'd0, 1'b1, 20'd0));
    pending_words.push_back(make_word(CMD_NB_RECV, 8'h5A, 15'h2AAA, 1'b0, 20'h55555));
    pending_words.push_back(make_word(CMD_B_SEND, 8'h5A, 15'h5555, 1'b1, 20'hAAAAA));
    pending_words.push_back(make_word(CMD_NB_SEND, 8'h01, 15'd3, 1'b0, 20'd10));
    pending_words.push_back(make_word(CMD_B_RECV, 8'h01, 15'd3, 1'b0, 20'd10));
    pending_words.push_back(make_word(CMD_NB_SEND, 8'h01, 15'd4, 1'b0, 20'd5));
    pending_words.push_back(make_word(CMD_B_RECV, 8'h02, 15'd4, 1'b0, 20'd5));
    repeat (17) pending_words.push_back(make_word(CMD_NB_RECV, 8'h07, 15'd1, 1'b0, 20'd9));
    drain();
    // Drain the full receive queue with blocking sends.
    repeat (16) pending_words.push_back(make_word(CMD_B_SEND, 8'h07, 15'd1, 1'b0, 20'd9));
    pending_words.push_back(make_word(CMD_B_SEND, 8'h01, 15'd4, 1'b0, 20'd5));
    drain();

    run_random(90, 0, 0);
    run_random(90, 69, 0);
    run_random(90, 0, 69);
    run_random(90, 27, 27);

    hold_cycles = 300;
    repeat (40) pending_words.push_back(random_word());
    drain();
    sender_pause = 1'b1;
    repeat (20) pending_words.push_back(random_word());
    repeat (3) @(posedge clk_i);
    sender_pause = 1'b0;
    drain();

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
